// File: rtl/core/sfwd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfwd_pkg
// Shared types and constants for the scale frame weight decoder.
// ----------------------------------------------------------------------------
package sfwd_pkg;

    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 6;
    localparam int SUM_W     = 16;
    localparam int WORD_W    = 16;
    localparam int WEIGHT_W  = 23;
    localparam int STATUS_W  = 2;

    localparam logic [COUNT_W-1:0] MAX_FRAME_BYTES = 6'd32;
    localparam logic [COUNT_W-1:0] COUNT_CEILING   = 6'd63;

    // frame byte positions
    localparam logic [COUNT_W-1:0] IDX_HIGH  = 6'd5;
    localparam logic [COUNT_W-1:0] IDX_LOW   = 6'd6;
    localparam logic [COUNT_W-1:0] IDX_FLAGS = 6'd7;

    // top-bit patterns
    localparam logic [1:0] TAG_START = 2'b10;
    localparam logic [1:0] TAG_CLOSE = 2'b11;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_GOOD   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CSUM   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LENGTH = 2'd2;

    // word * 15000 / 158 == word * 7500 / 79 == word * 94 + word * 74 / 79
    localparam logic [WEIGHT_W-1:0] SCALE_WHOLE = 23'd94;
    localparam logic [WEIGHT_W-1:0] SCALE_REM   = 23'd74;
    // ceil(2^30 / 79), exact for dividends below 2^23
    localparam int                  RECIP_W     = 24;
    localparam logic [RECIP_W-1:0]  RECIP_79    = 24'd13591669;
    localparam int                  RECIP_SHIFT = 30;
    localparam int                  PROD_W      = WEIGHT_W + RECIP_W;
    localparam int                  QUOT_W      = PROD_W - RECIP_SHIFT;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX  = 23'd6221677;

    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   word;
    } sfwd_close_t;

    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [WEIGHT_W-1:0] weight;
    } sfwd_result_t;

endpackage

// File: rtl/core/sfwd_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfwd_frame
// Byte-level framing, running checksum and field capture; registers one
// close record per frame end.
// ----------------------------------------------------------------------------
module sfwd_frame
    import sfwd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,      // pipeline moves
    input  logic                take,     // byte accepted (implies adv)
    input  logic [BYTE_W-1:0]   rx_byte,
    output sfwd_close_t         close_o
);

    logic               in_frame_reg,  in_frame_next;
    logic [COUNT_W-1:0] count_reg,     count_next;
    logic [SUM_W-1:0]   sum_reg,       sum_next;
    logic [BYTE_W-1:0]  prev_reg,      prev_next;
    logic [BYTE_W-1:0]  high_reg,      high_next;
    logic [BYTE_W-1:0]  low_reg,       low_next;
    logic [BYTE_W-1:0]  flags_reg,     flags_next;
    sfwd_close_t        close_reg,     close_next;

    logic [SUM_W-1:0]   body;
    logic [WORD_W-1:0]  folded;
    logic [WORD_W-1:0]  received;
    logic [BYTE_W-1:0]  flags_now;
    logic               len_bad;

    always_comb begin
        body      = sum_reg - SUM_W'(prev_reg);
        folded    = ({body[14:0], 1'b0} & 16'hFF00) | (body & 16'h007F) | 16'hC000;
        received  = {rx_byte, prev_reg};
        // an eight-byte frame closes on the flags byte itself
        flags_now = (count_reg == IDX_FLAGS) ? rx_byte : flags_reg;
        len_bad   = (count_reg < IDX_FLAGS) || (count_reg >= MAX_FRAME_BYTES);
    end

    always_comb begin
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        prev_next     = prev_reg;
        high_next     = high_reg;
        low_next      = low_reg;
        flags_next    = flags_reg;
        close_next    = '0;

        if (take) begin
            if (!in_frame_reg) begin
                if (rx_byte[7:6] == TAG_START) begin
                    in_frame_next = 1'b1;
                    count_next    = COUNT_W'(1);
                    sum_next      = SUM_W'(rx_byte);
                    prev_next     = rx_byte;
                end
            end else begin
                if (count_reg == IDX_HIGH)  high_next  = rx_byte;
                if (count_reg == IDX_LOW)   low_next   = rx_byte;
                if (count_reg == IDX_FLAGS) flags_next = rx_byte;

                if (rx_byte[7:6] != TAG_CLOSE) begin
                    sum_next  = sum_reg + SUM_W'(rx_byte);
                    prev_next = rx_byte;
                    if (count_reg != COUNT_CEILING) begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                end else begin
                    in_frame_next    = 1'b0;
                    count_next       = '0;
                    sum_next         = '0;
                    prev_next        = '0;
                    close_next.valid = 1'b1;
                    close_next.word  = {high_reg[7] | flags_now[0], high_reg[6:0],
                                        low_reg[7]  | flags_now[1], low_reg[6:0]};
                    priority if (len_bad) begin
                        close_next.status = ST_LENGTH;
                    end else if (folded != received) begin
                        close_next.status = ST_CSUM;
                    end else begin
                        close_next.status = ST_GOOD;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
            sum_reg      <= '0;
            prev_reg     <= '0;
            high_reg     <= '0;
            low_reg      <= '0;
            flags_reg    <= '0;
            close_reg    <= '0;
        end else if (adv) begin
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            prev_reg     <= prev_next;
            high_reg     <= high_next;
            low_reg      <= low_next;
            flags_reg    <= flags_next;
            close_reg    <= close_next;
        end
    end

    assign close_o = close_reg;

endmodule

// File: rtl/core/sfwd_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfwd_scale
// Two-stage constant scaling of the raw word by 15000/158, truncated,
// using a reciprocal multiply for the division by 79.
// ----------------------------------------------------------------------------
module sfwd_scale
    import sfwd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         adv,
    input  sfwd_close_t  close_i,
    output sfwd_result_t result_o
);

    // stage 1: split into whole and remainder parts
    logic                v1_reg;
    logic [STATUS_W-1:0] st1_reg;
    logic [WEIGHT_W-1:0] base1_reg;
    logic [WEIGHT_W-1:0] rem1_reg;

    // stage 2: reciprocal product
    logic                v2_reg;
    logic [STATUS_W-1:0] st2_reg;
    logic [WEIGHT_W-1:0] base2_reg;
    logic [PROD_W-1:0]   prod2_reg;

    logic [QUOT_W-1:0]   quot;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= close_i.valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st1_reg   <= close_i.status;
            base1_reg <= WEIGHT_W'(close_i.word) * SCALE_WHOLE;
            rem1_reg  <= WEIGHT_W'(close_i.word) * SCALE_REM;
            st2_reg   <= st1_reg;
            base2_reg <= base1_reg;
            prod2_reg <= PROD_W'(rem1_reg) * PROD_W'(RECIP_79);
        end
    end

    assign quot = prod2_reg[PROD_W-1:RECIP_SHIFT];

    always_comb begin
        result_o.valid  = v2_reg;
        result_o.status = st2_reg;
        result_o.weight = (st2_reg == ST_GOOD) ? base2_reg + WEIGHT_W'(quot) : '0;
    end

endmodule

// File: rtl/core/scale_frame_weight_decoder.sv
`timescale 1ns / 1ps
// Path: a closing byte's result reaches the output register through the frame
//   register (loaded on the edge that takes the byte), then two scaling
//   stages, then the output register.
// Throughput: one byte per cycle; the whole pipeline moves together and only
//   halts while the output register holds a result the sink has not taken.
// Reset (aresetn low, synchronous): hunting for a start byte, frame state
//   cleared, pipeline and output empty.
// ----------------------------------------------------------------------------
// scale_frame_weight_decoder
// Decodes the serial byte stream of a weighing scale into weight readings,
// one reading with status per frame close.
// ----------------------------------------------------------------------------
module scale_frame_weight_decoder
    import sfwd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    // byte stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte

    // readings out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [22:0] weight_value, [23] zero
    output logic [1:0]  m_axis_tuser    // [1:0] frame_status
);

    logic         pipe_adv;     // every stage advances this cycle
    logic         byte_take;    // input request accepted
    sfwd_close_t  close_rec;
    sfwd_result_t scaled;

    logic                m_valid_reg;
    logic [WEIGHT_W-1:0] m_weight_reg;
    logic [STATUS_W-1:0] m_status_reg;

    // The output register is the only place a result can wait; when it is
    // empty or being drained, all stages shift and a new byte is taken.
    assign pipe_adv      = !m_valid_reg || m_axis_tready;
    assign byte_take     = s_axis_tvalid && pipe_adv;
    assign s_axis_tready = pipe_adv;

    // framing, checksum, byte capture
    sfwd_frame u_frame (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (pipe_adv),
        .take    (byte_take),
        .rx_byte (s_axis_tdata),
        .close_o (close_rec)
    );

    // word * 15000 / 158
    sfwd_scale u_scale (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (pipe_adv),
        .close_i  (close_rec),
        .result_o (scaled)
    );

    // output register: loads a bubble or a result whenever the pipe moves
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_adv) begin
            m_valid_reg <= scaled.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            m_weight_reg <= scaled.weight;
            m_status_reg <= scaled.status;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, m_weight_reg};
    assign m_axis_tuser  = m_status_reg;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------

    // a bad frame never carries a weight
    a_bad_frame_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tuser != ST_GOOD)) |-> (m_axis_tdata == 24'd0))
        else $error("non-zero weight on a bad frame");

    // scaled reading never exceeds the scaled maximum of a 16-bit word
    a_weight_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[22:0] <= WEIGHT_MAX))
        else $error("weight beyond scaled range");

    // while the output stalls, the frame record must hold still
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(close_rec))
        else $error("frame record moved during stall");

endmodule
